/* rtl/mad_outlier_threshold_macros.svh */
// assertion helpers
`ifndef MAD_OUTLIER_THRESHOLD_MACROS_SVH
`define MAD_OUTLIER_THRESHOLD_MACROS_SVH
`ifndef SYNTHESIS
`define MOT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MOT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MOT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/mot_pkg.sv */
package mot_pkg;
    localparam int MaxSamples  = 1024;
    localparam int AddrW       = $clog2(MaxSamples);
    localparam int CountW      = AddrW + 1;
    localparam int DataW       = 32;
    localparam int ScaleW      = 16;
    localparam logic [ScaleW-1:0] ScaleReset = 16'd768;
    localparam logic [31:0] SigmaFactor = 32'd1591907810;

    typedef struct packed {
        logic              start;
        logic [CountW-1:0] n;
        logic [AddrW-1:0]  k;
    } t_sel_cmd;
endpackage

/* rtl/mad_outlier_threshold.sv */
// Load: one residual per cycle; tready stays high while loading.
// On the last residual: copy pass, quickselect, deviation pass, second
// quickselect, then scaling through states S_M1 to S_M4. Result held in an
// output register until taken; ready is low until then. Synchronous
// active-low reset clears control, scale to 3.0.
`include "mad_outlier_threshold_macros.svh"
module mad_outlier_threshold
    import mot_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // residual[31:0]
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // median_value, robust_sigma, threshold
    output logic        m_axis_tuser    // saturated
);
    typedef enum logic [9:0] {
        S_LOAD = 10'b0000000001,
        S_CP   = 10'b0000000010,
        S_SEL1 = 10'b0000000100,
        S_DEV  = 10'b0000001000,
        S_SEL2 = 10'b0000010000,
        S_M1   = 10'b0000100000,
        S_M2   = 10'b0001000000,
        S_M3   = 10'b0010000000,
        S_M4   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [DataW-1:0] r_orig [MaxSamples];
    logic [DataW-1:0] r_ord;
    logic [CountW-1:0] r_cnt, r_idx;
    logic [ScaleW-1:0] r_scale;
    logic [DataW-1:0] r_med, r_mad, r_sig, r_thr;
    logic [63:0] r_prod;
    logic r_sat, r_rv;
    t_sel_cmd w_cmd;
    logic w_sdone, w_we;
    logic [DataW-1:0] w_sres, w_wd;
    logic [AddrW-1:0] w_wa;
    logic w_acc;

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (w_acc && r_cnt < CountW'(MaxSamples))
            r_orig[r_cnt[AddrW-1:0]] <= s_axis_tdata;
        r_ord <= r_orig[r_idx[AddrW-1:0]];
    end

    // copy / deviation passes: read at r_idx, write at r_idx-1 in the next cycle
    assign w_we = (r_state == S_CP || r_state == S_DEV) && r_idx != '0 && r_idx <= r_cnt;
    assign w_wa = AddrW'(r_idx - 1'b1);
    assign w_wd = (r_state == S_CP) ? r_ord : ((r_ord > r_med) ? r_ord - r_med : r_med - r_ord);

    always_comb begin
        w_cmd.start = (r_state == S_CP || r_state == S_DEV) && r_idx == r_cnt;
        w_cmd.n = r_cnt;
        w_cmd.k = AddrW'((r_cnt - 1'b1) >> 1);
    end

    mot_select u_sel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_wr_en(w_we), .i_wr_addr(w_wa), .i_wr_data(w_wd),
        .o_done(w_sdone), .o_result(w_sres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0;
            r_idx <= '0;
            r_scale <= ScaleReset;
            r_rv <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_scale <= i_cfg_wdata;
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (r_cnt < CountW'(MaxSamples))
                            r_cnt <= r_cnt + 1'b1;
                        if (s_axis_tlast) begin
                            r_idx <= '0;
                            r_state <= S_CP;
                        end
                    end
                end
                S_CP, S_DEV: begin
                    if (r_idx == r_cnt)
                        r_state <= (r_state == S_CP) ? S_SEL1 : S_SEL2;
                    else
                        r_idx <= r_idx + 1'b1;
                end
                S_SEL1: if (w_sdone) begin
                    r_med <= w_sres;
                    r_idx <= '0;
                    r_state <= S_DEV;
                end
                S_SEL2: if (w_sdone) begin
                    r_mad <= w_sres;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_prod <= 64'(r_mad) * 64'(SigmaFactor);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_sat <= |((r_prod + 64'd536870912) >> 62);
                    r_sig <= |((r_prod + 64'd536870912) >> 62) ? '1
                             : 32'((r_prod + 64'd536870912) >> 30);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_prod <= 64'(r_scale) * 64'(r_sig) + 64'd128;
                    r_state <= S_M4;
                end
                S_M4: begin
                    if (((r_prod >> 8) + 64'(r_med)) > 64'hFFFFFFFF) begin
                        r_thr <= '1;
                        r_sat <= 1'b1;
                    end else
                        r_thr <= 32'((r_prod >> 8) + 64'(r_med));
                    r_rv <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) begin
                    r_rv <= 1'b0;
                    r_cnt <= '0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_rv;
    assign m_axis_tdata = {r_thr, r_sig, r_med};
    assign m_axis_tuser = r_sat;

    `MOT_ASSERT_IMPL(a_out_state, i_clk, i_rst_n, m_axis_tvalid, r_state == S_OUT)
    `MOT_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CountW'(MaxSamples))
    `MOT_ASSERT_NEXT(a_last_leaves, i_clk, i_rst_n, w_acc && s_axis_tlast, !s_axis_tready)
endmodule

/* rtl/mot_select.sv */
// quickselect (Hoare partition) over a single-port scratch memory
module mot_select
    import mot_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_sel_cmd         i_cmd,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [DataW-1:0] i_wr_data,
    output logic             o_done,
    output logic [DataW-1:0] o_result
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PIV   = 11'b00000000010,
        S_PIVW  = 11'b00000000100,
        S_RDI   = 11'b00000001000,
        S_CHKI  = 11'b00000010000,
        S_RDJ   = 11'b00000100000,
        S_CHKJ  = 11'b00001000000,
        S_SWPI  = 11'b00010000000,
        S_SWPJ  = 11'b00100000000,
        S_NEXT  = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

    logic [DataW-1:0] r_mem [MaxSamples];
    logic [DataW-1:0] r_rd;
    logic [AddrW-1:0] n_addr;
    logic             n_we;
    logic [DataW-1:0] n_wd;

    t_state r_state, n_state;
    logic signed [CountW:0] r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_j, n_j;
    logic [AddrW-1:0] r_k, n_k;
    logic [DataW-1:0] r_piv, n_piv, r_vi, n_vi, r_vj, n_vj;
    logic             n_done;
    logic [CountW:0]  w_mid;

    always_ff @(posedge i_clk) begin
        if (n_we)
            r_mem[n_addr] <= n_wd;
        r_rd <= r_mem[n_addr];
    end

    assign w_mid = CountW'(0) + (($unsigned(r_lo) + $unsigned(r_hi)) >> 1);

    always_comb begin
        n_state = r_state;
        n_lo = r_lo; n_hi = r_hi; n_i = r_i; n_j = r_j; n_k = r_k;
        n_piv = r_piv; n_vi = r_vi; n_vj = r_vj; n_done = 1'b0;
        n_addr = i_wr_addr; n_we = 1'b0; n_wd = i_wr_data;
        case (r_state)
            S_IDLE: begin
                n_we = i_wr_en;
                if (i_cmd.start) begin
                    n_lo = '0;
                    n_hi = (CountW+1)'(i_cmd.n) - 1'b1;
                    n_k = i_cmd.k;
                    n_state = S_PIV;
                end
            end
            S_PIV: begin
                if (r_lo < r_hi) begin
                    n_addr = w_mid[AddrW-1:0];
                    n_i = r_lo; n_j = r_hi;
                    n_state = S_PIVW;
                end else begin
                    n_addr = r_k;
                    n_state = S_FIN;
                end
            end
            S_PIVW: begin
                n_piv = r_rd;
                n_addr = r_i[AddrW-1:0];
                n_state = S_CHKI;
            end
            S_RDI: begin
                n_addr = r_i[AddrW-1:0];
                n_state = S_CHKI;
            end
            S_CHKI: begin
                if (r_rd < r_piv) begin
                    n_i = r_i + 1'b1;
                    n_addr = n_i[AddrW-1:0];
                end else begin
                    n_vi = r_rd;
                    n_addr = r_j[AddrW-1:0];
                    n_state = S_CHKJ;
                end
            end
            S_RDJ: begin
                n_addr = r_j[AddrW-1:0];
                n_state = S_CHKJ;
            end
            S_CHKJ: begin
                if (r_rd > r_piv) begin
                    n_j = r_j - 1'b1;
                    n_addr = n_j[AddrW-1:0];
                end else begin
                    n_vj = r_rd;
                    n_state = (r_i <= r_j) ? S_SWPI : S_NEXT;
                end
            end
            S_SWPI: begin
                n_we = 1'b1; n_addr = r_i[AddrW-1:0]; n_wd = r_vj;
                n_state = S_SWPJ;
            end
            S_SWPJ: begin
                n_we = 1'b1; n_addr = r_j[AddrW-1:0]; n_wd = r_vi;
                n_i = r_i + 1'b1; n_j = r_j - 1'b1;
                n_state = (n_i <= n_j) ? S_RDI : S_NEXT;
            end
            S_NEXT: begin
                if ($signed({1'b0, r_k}) <= r_j) begin
                    n_hi = r_j; n_state = S_PIV;
                end else if ($signed({1'b0, r_k}) >= r_i) begin
                    n_lo = r_i; n_state = S_PIV;
                end else begin
                    n_addr = r_k; n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_piv <= n_piv; r_vi <= n_vi; r_vj <= n_vj;
    end

    assign o_done = n_done;
    assign o_result = r_rd;
endmodule

/* sim/mad_outlier_threshold_checker.sv */
module mad_outlier_threshold_checker
    import mot_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] median;
        logic [31:0] sigma;
        logic [31:0] threshold;
        logic        sat;
    } t_stats;

    logic [31:0]       residual_set[$];
    t_stats            stats_due[$];
    logic [ScaleW-1:0] scale;

    function automatic logic [31:0] lower_median(logic [31:0] vals[$]);
        logic [31:0] srt[$];
        srt = vals;
        srt.sort();
        return srt[(srt.size() - 1) >> 1];
    endfunction

    function automatic t_stats robust_stats(logic [31:0] vals[$], logic [ScaleW-1:0] scl);
        logic [31:0] devs[$];
        logic [31:0] med;
        logic [31:0] mad;
        logic [63:0] sig;
        logic [63:0] thr;
        t_stats      res;
        med = lower_median(vals);
        foreach (vals[i])
            devs.push_back(vals[i] > med ? vals[i] - med : med - vals[i]);
        mad = lower_median(devs);
        res.sat = 1'b0;
        sig = (64'(mad) * 64'(SigmaFactor) + (64'd1 << 29)) >> 30;
        if (sig > 64'hFFFF_FFFF) begin
            sig = 64'hFFFF_FFFF;
            res.sat = 1'b1;
        end
        thr = ((64'(scl) * sig + 64'd128) >> 8) + 64'(med);
        if (thr > 64'hFFFF_FFFF) begin
            thr = 64'hFFFF_FFFF;
            res.sat = 1'b1;
        end
        res.median    = med;
        res.sigma     = sig[31:0];
        res.threshold = thr[31:0];
        return res;
    endfunction

    initial o_errors = 0;
    assign o_pending = stats_due.size();

    always @(posedge i_clk) begin
        t_stats got;
        t_stats want;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            residual_set.delete();
            stats_due.delete();
            scale <= ScaleReset;
        end else begin
            if (i_cfg_we)
                scale <= i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                if (residual_set.size() < MaxSamples)
                    residual_set.push_back(s_axis_tdata);
                if (s_axis_tlast) begin
                    stats_due.push_back(robust_stats(residual_set, scale));
                    residual_set.delete();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                       m_axis_tuser};
                if (stats_due.size() == 0) begin
                    $error("unexpected result transfer: %h", got);
                    errs++;
                end else begin
                    want = stats_due.pop_front();
                    if (got.median !== want.median) begin
                        $error("median_value exp %h got %h", want.median, got.median);
                        errs++;
                    end
                    if (got.sigma !== want.sigma) begin
                        $error("robust_sigma exp %h got %h", want.sigma, got.sigma);
                        errs++;
                    end
                    if (got.threshold !== want.threshold) begin
                        $error("threshold exp %h got %h", want.threshold, got.threshold);
                        errs++;
                    end
                    if (got.sat !== want.sat) begin
                        $error("saturated exp %b got %b", want.sat, got.sat);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end
endmodule

/* sim/mad_outlier_threshold_tb.sv */
module mad_outlier_threshold_tb;
    import mot_pkg::*;

    localparam int CycleLimit = 6000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          errors;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          cycles;

    mad_outlier_threshold i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    mad_outlier_threshold_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[mad_outlier_threshold] ERROR");
            $finish;
        end
    end

    // result side: random stall, long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_cnt == 0)
                hold_cnt = 3000;
            if (hold_cnt > 0) begin
                hold_cnt--;
                if (hold_cnt == 0)
                    hold_req = 1'b0;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_residual(logic [31:0] r, logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_set(logic [31:0] vals[$]);
        foreach (vals[i])
            send_residual(vals[i], i == vals.size() - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_scale(logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] rand_residual(int mode);
        case (mode)
            0:       return $urandom();
            1:       return $urandom_range(8);
            2:       return 32'(1) << $urandom_range(31);
            default: return $urandom_range(32'h0010_0000);
        endcase
    endfunction

    initial begin
        logic [31:0] set_vals[$];
        logic [15:0] scales[6];
        int          sent;
        int          n;
        int          mode;
        scales = '{16'd0, 16'hFFFF, 16'd256, 16'd1, 16'h8000, 16'd768};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset scale
        send_set('{32'd0});
        send_set('{32'hFFFF_FFFF});
        send_set('{32'd0, 32'hFFFF_FFFF});
        send_set('{32'd0, 32'h8000_0000, 32'hFFFF_FFFF});
        send_set('{32'd5, 32'd5, 32'd5, 32'd5});
        send_set('{32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0009_0000,
                   32'h0004_0000});
        // store full: two residuals dropped, last one among them
        set_vals.delete();
        for (int i = 0; i < MaxSamples + 2; i++)
            set_vals.push_back($urandom());
        send_set(set_vals);
        drain();

        write_scale(16'hFFFF);
        send_set('{32'd0, 32'h8000_0000, 32'hFFFF_FFFF});
        send_set('{32'h0001_0000, 32'h0002_0000, 32'h0007_0000});
        drain();
        write_scale(16'd0);
        send_set('{32'd0, 32'h8000_0000, 32'hFFFF_FFFF});
        send_set('{32'h0000_0001});
        drain();

        // receiver holds off while sets keep coming
        hold_req = 1'b1;
        for (int s = 0; s < 4; s++)
            send_set('{$urandom(), $urandom(), $urandom()});
        drain();

        sent = 0;
        for (int p = 0; p < 6; p++) begin
            write_scale(scales[p] == 16'h8000 ? 16'($urandom()) : scales[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            while (sent < 70 * (p + 1)) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 12);
                if (n == 0)
                    n = 1;
                mode = $urandom_range(3);
                set_vals.delete();
                for (int i = 0; i < n; i++)
                    set_vals.push_back(rand_residual(mode));
                send_set(set_vals);
                sent += n;
            end
            drain();
        end

        if (errors == 0)
            $display("[mad_outlier_threshold] OK");
        else
            $display("[mad_outlier_threshold] ERROR");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/mot_pkg.sv
rtl/mot_select.sv
rtl/mad_outlier_threshold.sv
sim/mad_outlier_threshold_checker.sv
sim/mad_outlier_threshold_tb.sv
